FILE: design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types, constants and helpers of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int ADDR_W   = 12;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int HDR_W    = 49;

    localparam logic [1:0]  OP_INIT  = 2'd0;
    localparam logic [1:0]  OP_ALLOC = 2'd1;
    localparam logic [1:0]  OP_FREE  = 2'd2;

    localparam logic [15:0] HEAP_HDR   = 16'd8;
    localparam logic [15:0] BLK_HDR    = 16'd8;
    localparam logic [16:0] GRANULE    = 17'd16;
    localparam logic [16:0] HEAP_MIN   = 17'd64;
    localparam logic [16:0] HEAP_MAX   = 17'd65536;
    localparam logic [16:0] HEAP_RESET = 17'd65536;
    localparam logic [12:0] STEP_LIMIT = 13'd4096;

    typedef struct packed {
        logic [15:0] prev;
        logic [16:0] size;
        logic [15:0] next;
    } t_hdr;

    localparam t_hdr MASK_PREV = '{prev: '1, size: '0, next: '0};
    localparam t_hdr MASK_SIZE = '{prev: '0, size: '1, next: '0};
    localparam t_hdr MASK_NEXT = '{prev: '0, size: '0, next: '1};
    localparam t_hdr MASK_ALL  = '{prev: '1, size: '1, next: '1};

    function automatic logic [ADDR_W-1:0] hdr_idx(input logic [15:0] off);
        return off[ADDR_W+3:4];
    endfunction

endpackage

FILE: design/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha interfaces
// request, response and configuration channels of the heap allocator
// ----------------------------------------------------------------------------
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] request_size;
    logic [15:0] release_pointer;
    modport source (output valid, opcode, request_size, release_pointer, input ready);
    modport sink   (input valid, opcode, request_size, release_pointer, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] granted_pointer;
    logic        status;
    modport source (output valid, granted_pointer, status, input ready);
    modport sink   (input valid, granted_pointer, status, output ready);
endinterface

interface ffha_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] heap_bytes;
    modport source (output valid, heap_bytes, input ready);
    modport sink   (input valid, heap_bytes, output ready);
endinterface

FILE: design/ffha_hdr_ram.sv
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// single-port block header ram with bit write mask and registered read
// ----------------------------------------------------------------------------
module ffha_hdr_ram #(
    parameter int DATA_W = 49,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wmask,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];

    always_ff @(posedge i_clk) begin
        r_mem[i_addr] <= (r_mem[i_addr] & ~i_wmask) | (i_wdata & i_wmask);
        o_rdata       <= r_mem[i_addr];
    end

endmodule

FILE: design/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit allocator over an address-ordered doubly linked free list
// ----------------------------------------------------------------------------
// One request is handled at a time; the block is not ready while it works.
// All header traffic goes through one single-port header ram, so cost is set
// by that port: init writes the heap header; allocate goes straight to done
// on an empty list, else walks the free list and then splits the block found
// or takes it whole (a failed search ends with the walk); a null or misaligned
// free goes straight to done, a free into an empty list sets the head, else it
// walks to the insertion point, links the block in and merges it with adjacent
// free neighbours. A finished word waits in the output register, and the next
// request is taken meanwhile; a word that is still waiting holds the next one
// in its last cycle.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffha_req_if.sink    i_req,
    ffha_rsp_if.source  o_rsp,
    ffha_cfg_if.sink    i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_A_RD, S_A_WALK, S_A_S1, S_A_S2, S_A_S3, S_A_S4,
        S_A_W1, S_A_W2, S_F_EMPTY, S_F_CHK, S_F_RD, S_F_RDIT, S_F_I1, S_F_I2,
        S_F_I3, S_F_TAIL, S_F_TB, S_M_RB, S_M_B, S_M_N, S_M_N2, S_M_P, S_M_PD,
        S_M_P2, S_DONE
    } t_state;

    t_state      r_state;
    logic [16:0] r_heap_bytes;
    logic [15:0] r_head;
    logic [15:0] r_off, r_pv, r_nx, r_it, r_tail;
    logic [16:0] r_sz, r_need, r_bsz;
    logic [12:0] r_steps;
    logic [15:0] r_gptr;
    logic        r_fail;
    logic        r_ovalid;
    logic [15:0] r_optr;
    logic        r_ostat;

    logic [ADDR_W-1:0] w_addr;
    t_hdr        w_wmask, w_wdata, w_rd;
    logic [15:0] w_noff;
    logic [16:0] w_hs;
    logic [16:0] w_need_in;
    logic        w_accept;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.granted_pointer = r_optr;
    assign o_rsp.status = r_ostat;

    assign w_noff    = r_off + r_need[15:0];
    assign w_need_in = ({1'b0, i_req.request_size} + 17'd23) & ~17'hf;
    assign w_hs      = (r_heap_bytes < HEAP_MIN) ? HEAP_MIN :
                       (r_heap_bytes > HEAP_MAX) ? HEAP_MAX : r_heap_bytes;

    ffha_hdr_ram #(.DATA_W(HDR_W), .ADDR_W(ADDR_W)) u_ram (
        .i_clk   (i_clk),
        .i_addr  (w_addr),
        .i_wmask (w_wmask),
        .i_wdata (w_wdata),
        .o_rdata (w_rd)
    );

    // header port: one read or one masked write a cycle
    always_comb begin
        w_addr  = hdr_idx(r_off);
        w_wmask = '0;
        w_wdata = '0;
        unique case (r_state)
            S_INIT: begin
                w_addr  = hdr_idx(HEAP_HDR);
                w_wmask = MASK_ALL;
                w_wdata = '{prev: 16'd0, size: w_hs - 17'd8, next: 16'd0};
            end
            S_A_WALK: w_addr = hdr_idx(w_rd.next);
            S_A_S1: begin
                w_addr  = hdr_idx(w_noff);
                w_wmask = MASK_ALL;
                w_wdata = '{prev: r_pv, size: r_sz - r_need, next: r_nx};
            end
            S_A_S2: begin
                w_addr  = hdr_idx(r_nx);
                w_wmask = (r_nx != 16'd0) ? MASK_PREV : '0;
                w_wdata.prev = w_noff;
            end
            S_A_S3: begin
                w_addr  = hdr_idx(r_pv);
                w_wmask = (r_pv != 16'd0) ? MASK_NEXT : '0;
                w_wdata.next = w_noff;
            end
            S_A_S4: begin
                w_wmask = MASK_SIZE;
                w_wdata.size = r_need;
            end
            S_A_W1: begin
                w_addr  = hdr_idx(r_pv);
                w_wmask = (r_pv != 16'd0) ? MASK_NEXT : '0;
                w_wdata.next = r_nx;
            end
            S_A_W2: begin
                w_addr  = hdr_idx(r_nx);
                w_wmask = (r_nx != 16'd0) ? MASK_PREV : '0;
                w_wdata.prev = r_pv;
            end
            S_F_EMPTY: begin
                w_wmask = MASK_PREV | MASK_NEXT;
            end
            S_F_CHK: w_addr = hdr_idx(r_it);
            S_F_I1: begin
                w_addr  = hdr_idx(r_pv);
                w_wmask = (r_pv != 16'd0) ? MASK_NEXT : '0;
                w_wdata.next = r_off;
            end
            S_F_I2: begin
                w_wmask = MASK_PREV | MASK_NEXT;
                w_wdata.prev = r_pv;
                w_wdata.next = r_it;
            end
            S_F_I3: begin
                w_addr  = hdr_idx(r_it);
                w_wmask = MASK_PREV;
                w_wdata.prev = r_off;
            end
            S_F_TAIL: begin
                w_addr  = hdr_idx(r_tail);
                w_wmask = MASK_NEXT;
                w_wdata.next = r_off;
            end
            S_F_TB: begin
                w_wmask = MASK_PREV | MASK_NEXT;
                w_wdata.prev = r_tail;
            end
            S_M_B: w_addr = hdr_idx(w_rd.next);
            S_M_N: begin
                w_wmask = MASK_SIZE | MASK_NEXT;
                w_wdata.size = r_bsz + w_rd.size;
                w_wdata.next = w_rd.next;
            end
            S_M_N2: begin
                w_addr  = hdr_idx(r_nx);
                w_wmask = (r_nx != 16'd0) ? MASK_PREV : '0;
                w_wdata.prev = r_off;
            end
            S_M_P: w_addr = hdr_idx(r_pv);
            S_M_PD: begin
                w_addr = hdr_idx(r_pv);
                if (({2'b0, r_pv} + {1'b0, w_rd.size}) == {2'b0, r_off}) begin
                    w_wmask = MASK_SIZE | MASK_NEXT;
                end
                w_wdata.size = w_rd.size + r_bsz;
                w_wdata.next = r_nx;
            end
            S_M_P2: begin
                w_addr  = hdr_idx(r_nx);
                w_wmask = (r_nx != 16'd0) ? MASK_PREV : '0;
                w_wdata.prev = r_pv;
            end
            default: w_addr = hdr_idx(r_off);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_bytes <= HEAP_RESET;
            r_head       <= 16'd0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_heap_bytes <= i_cfg.heap_bytes;
            end
            if (r_ovalid && o_rsp.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_gptr  <= 16'd0;
                        r_fail  <= (i_req.opcode == OP_ALLOC) && (r_head == 16'd0);
                        r_need  <= w_need_in;
                        r_steps <= '0;
                        r_tail  <= 16'd0;
                        r_it    <= r_head;
                        priority case (i_req.opcode)
                            OP_INIT: r_state <= S_INIT;
                            OP_ALLOC: begin
                                r_off   <= r_head;
                                r_state <= (r_head == 16'd0) ? S_DONE : S_A_RD;
                            end
                            OP_FREE: begin
                                r_off <= i_req.release_pointer - BLK_HDR;
                                if (i_req.release_pointer != 16'd0 &&
                                    i_req.release_pointer[3:0] == 4'd0) begin
                                    r_state <= (r_head == 16'd0) ? S_F_EMPTY : S_F_CHK;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_INIT: begin
                    r_head  <= HEAP_HDR;
                    r_state <= S_DONE;
                end
                S_A_RD: r_state <= S_A_WALK;
                S_A_WALK: begin
                    if (w_rd.size < r_need && w_rd.next != 16'd0) begin
                        r_off   <= w_rd.next;
                        r_steps <= r_steps + 13'd1;
                        if (r_steps == STEP_LIMIT) begin
                            r_fail  <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end else if (w_rd.size < r_need) begin
                        r_fail  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_pv    <= w_rd.prev;
                        r_sz    <= w_rd.size;
                        r_nx    <= w_rd.next;
                        r_gptr  <= r_off + BLK_HDR;
                        r_state <= (w_rd.size - r_need >= GRANULE) ? S_A_S1 : S_A_W1;
                    end
                end
                S_A_S1: r_state <= S_A_S2;
                S_A_S2: r_state <= S_A_S3;
                S_A_S3: begin
                    if (r_off == r_head) begin
                        r_head <= w_noff;
                    end
                    r_state <= S_A_S4;
                end
                S_A_S4: r_state <= S_DONE;
                S_A_W1: r_state <= S_A_W2;
                S_A_W2: begin
                    if (r_off == r_head) begin
                        r_head <= (r_nx != 16'd0) ? r_nx : r_pv;
                    end
                    r_state <= S_DONE;
                end
                S_F_EMPTY: begin
                    r_head  <= r_off;
                    r_state <= S_DONE;
                end
                S_F_CHK: begin
                    if (r_it != 16'd0 && r_it < r_off) begin
                        r_tail  <= r_it;
                        r_state <= S_F_RD;
                    end else if (r_it == r_off) begin
                        r_state <= S_DONE;
                    end else if (r_it == 16'd0) begin
                        r_state <= S_F_TAIL;
                    end else begin
                        r_state <= S_F_RDIT;
                    end
                end
                S_F_RD: begin
                    r_it    <= w_rd.next;
                    r_steps <= r_steps + 13'd1;
                    r_state <= (r_steps == STEP_LIMIT) ? S_DONE : S_F_CHK;
                end
                S_F_RDIT: begin
                    r_pv    <= w_rd.prev;
                    r_state <= S_F_I1;
                end
                S_F_I1: r_state <= S_F_I2;
                S_F_I2: r_state <= S_F_I3;
                S_F_I3: begin
                    if (r_it == r_head) begin
                        r_head <= r_off;
                    end
                    r_state <= S_M_RB;
                end
                S_F_TAIL: r_state <= S_F_TB;
                S_F_TB:   r_state <= S_M_RB;
                S_M_RB:   r_state <= S_M_B;
                S_M_B: begin
                    r_pv  <= w_rd.prev;
                    r_nx  <= w_rd.next;
                    r_bsz <= w_rd.size;
                    if (w_rd.next != 16'd0 &&
                        ({2'b0, r_off} + {1'b0, w_rd.size}) == {2'b0, w_rd.next}) begin
                        r_state <= S_M_N;
                    end else begin
                        r_state <= S_M_P;
                    end
                end
                S_M_N: begin
                    r_bsz   <= r_bsz + w_rd.size;
                    r_nx    <= w_rd.next;
                    r_state <= S_M_N2;
                end
                S_M_N2: r_state <= S_M_P;
                S_M_P:  r_state <= (r_pv != 16'd0) ? S_M_PD : S_DONE;
                S_M_PD: begin
                    if (({2'b0, r_pv} + {1'b0, w_rd.size}) == {2'b0, r_off}) begin
                        r_state <= S_M_P2;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_M_P2: r_state <= S_DONE;
                S_DONE: begin
                    // hold the word until the output register is free
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_optr   <= r_gptr;
                        r_ostat  <= r_fail;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("request accepted but sequencer still idle");

    a_fail_no_pointer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ostat |-> r_optr == 16'd0)
        else $error("failed allocate carries a pointer");

    a_word_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("response raised outside completion");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_A_WALK || r_state == S_F_CHK || r_state == S_F_RD
        |-> r_steps <= STEP_LIMIT + 13'd1)
        else $error("walk step count out of range");
`endif

endmodule

FILE: sim/tb_first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// checks the allocator against a behavioural heap model: directed init,
// allocate and free cases, then random alloc/free traffic over several heap
// sizes, with bursty requests and a stalling response side
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator
    import ffha_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDEPTH = 4096;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();
    ffha_cfg_if cfg_ch ();

    first_fit_heap_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #10 i_clk = ~i_clk;

    typedef struct {
        logic [15:0] granted_pointer;
        logic        status;
    } t_word;

    // heap model state
    logic [15:0] hp_prev [HDEPTH];
    logic [16:0] hp_size [HDEPTH];
    logic [15:0] hp_next [HDEPTH];
    logic [15:0] hp_head;
    logic [16:0] hp_in_use;
    logic [16:0] hp_cfg_bytes;

    t_word       expected_words[$];
    logic [15:0] live_ptrs[$];
    int          mismatches;
    int          words_checked;
    int          allocs_ok;
    int          allocs_failed;
    int          frees_sent;
    bit          rsp_stall_mode;

    function automatic int gi(input logic [31:0] off);
        return (off / 16) % HDEPTH;
    endfunction

    function automatic void heap_init();
        logic [31:0] hs;
        hs = hp_cfg_bytes;
        if (hs < 64) hs = 64;
        if (hs > 65536) hs = 65536;
        hp_head = HEAP_HDR;
        hp_prev[gi(8)] = 16'd0;
        hp_size[gi(8)] = 17'(hs - 8);
        hp_next[gi(8)] = 16'd0;
        hp_in_use = '0;
    endfunction

    function automatic logic [15:0] heap_alloc(input logic [15:0] req, output logic fail);
        logic [31:0] need, off, pv, sz, nx, used, noff;
        int steps;
        need = (32'd8 + req + 32'd15) & ~32'd15;
        off = hp_head;
        steps = 0;
        fail = 1'b1;
        if (off == 0) return 16'd0;
        while (hp_size[gi(off)] < need && hp_next[gi(off)] != 0) begin
            off = hp_next[gi(off)];
            steps++;
            if (steps > HDEPTH) return 16'd0;
        end
        if (hp_size[gi(off)] < need) return 16'd0;
        pv = hp_prev[gi(off)];
        sz = hp_size[gi(off)];
        nx = hp_next[gi(off)];
        if (sz - need >= 16) begin
            noff = (off + need) & 32'hffff;
            hp_prev[gi(noff)] = pv[15:0];
            hp_size[gi(noff)] = 17'(sz - need);
            hp_next[gi(noff)] = nx[15:0];
            if (nx != 0) hp_prev[gi(nx)] = noff[15:0];
            if (pv != 0) hp_next[gi(pv)] = noff[15:0];
            if (off == hp_head) hp_head = noff[15:0];
            hp_size[gi(off)] = need[16:0];
            used = need;
        end else begin
            if (pv != 0) hp_next[gi(pv)] = nx[15:0];
            if (nx != 0) hp_prev[gi(nx)] = pv[15:0];
            if (off == hp_head) hp_head = (nx != 0) ? nx[15:0] : pv[15:0];
            used = sz;
        end
        hp_in_use = 17'(hp_in_use + used);
        fail = 1'b0;
        return 16'(off + 8);
    endfunction

    function automatic void heap_coalesce(input logic [31:0] off);
        logic [31:0] pv, nx, nn;
        pv = hp_prev[gi(off)];
        nx = hp_next[gi(off)];
        if (nx != 0 && off + hp_size[gi(off)] == nx) begin
            nn = hp_next[gi(nx)];
            hp_size[gi(off)] = 17'(hp_size[gi(off)] + hp_size[gi(nx)]);
            hp_next[gi(off)] = nn[15:0];
            if (nn != 0) hp_prev[gi(nn)] = off[15:0];
        end
        if (pv != 0 && pv + hp_size[gi(pv)] == off) begin
            hp_size[gi(pv)] = 17'(hp_size[gi(pv)] + hp_size[gi(off)]);
            hp_next[gi(pv)] = hp_next[gi(off)];
            if (hp_next[gi(off)] != 0) hp_prev[gi(hp_next[gi(off)])] = pv[15:0];
        end
    endfunction

    function automatic void heap_release(input logic [15:0] ptr);
        logic [31:0] off, it, tail, sz, pv;
        int steps;
        tail = 0;
        steps = 0;
        if (ptr == 0 || ptr[3:0] != 0) return;
        off = ptr - 8;
        it = 0;
        if (hp_head != 0) begin
            it = hp_head;
            while (it != 0 && it < off) begin
                tail = it;
                it = hp_next[gi(it)];
                steps++;
                if (steps > HDEPTH) return;
            end
            if (it == off) return;
        end
        sz = hp_size[gi(off)];
        hp_in_use = (hp_in_use >= sz) ? 17'(hp_in_use - sz) : 17'd0;
        if (hp_head == 0) begin
            hp_head = off[15:0];
            hp_prev[gi(off)] = '0;
            hp_next[gi(off)] = '0;
            return;
        end
        if (it == 0) begin
            hp_next[gi(tail)] = off[15:0];
            hp_prev[gi(off)] = tail[15:0];
            hp_next[gi(off)] = '0;
        end else begin
            pv = hp_prev[gi(it)];
            if (pv != 0) hp_next[gi(pv)] = off[15:0];
            hp_prev[gi(off)] = pv[15:0];
            hp_prev[gi(it)] = off[15:0];
            hp_next[gi(off)] = it[15:0];
            if (it == hp_head) hp_head = off[15:0];
        end
        heap_coalesce(off);
    endfunction

    // send one word, predicting its response at the accepting edge
    task automatic send_op(input logic [1:0] op, input logic [15:0] sz,
                           input logic [15:0] ptr);
        t_word w;
        logic f;
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.request_size <= sz;
        req_ch.release_pointer <= ptr;
        do @(posedge i_clk); while (!req_ch.ready);
        w.granted_pointer = 16'd0;
        w.status = 1'b0;
        case (op)
            OP_INIT: begin
                heap_init();
                live_ptrs.delete();
            end
            OP_ALLOC: begin
                w.granted_pointer = heap_alloc(sz, f);
                w.status = f;
                if (f) allocs_failed++;
                else begin
                    allocs_ok++;
                    live_ptrs.push_back(w.granted_pointer);
                end
            end
            OP_FREE: frees_sent++;
            default: ;
        endcase
        if (op == OP_FREE) heap_release(ptr);
        expected_words.push_back(w);
        // bursty sender
        if ($urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic idle_sender();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        idle_sender();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_heap_bytes(input logic [16:0] v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.heap_bytes <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        hp_cfg_bytes = v;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // free a random live block, sometimes a null or misaligned pointer
    task automatic free_some();
        int k;
        logic [15:0] p;
        if (live_ptrs.size() != 0 && $urandom_range(0, 9) != 0) begin
            k = $urandom_range(0, live_ptrs.size() - 1);
            p = live_ptrs[k];
            live_ptrs.delete(k);
        end else begin
            p = (live_ptrs.size() != 0 && $urandom_range(0, 1)) ?
                16'(live_ptrs[0] + 4) : 16'd0;
        end
        send_op(OP_FREE, 16'($urandom), p);
    endtask

    task automatic test_directed();
        logic [15:0] a, b, c;
        write_heap_bytes(17'd64);
        send_op(OP_ALLOC, 16'd0, 16'd0);     // empty list
        send_op(OP_FREE, 16'd0, 16'd0);      // null free on empty list
        send_op(OP_INIT, 16'hffff, 16'hffff);
        send_op(OP_ALLOC, 16'd40, 16'd0);    // whole block taken, no split
        send_op(OP_ALLOC, 16'd1, 16'd0);     // list empty
        send_op(OP_FREE, 16'd0, 16'd16);
        send_op(OP_FREE, 16'd0, 16'd16);     // double free
        send_op(OP_ALLOC, 16'hffff, 16'd0);  // oversized
        send_op(2'd3, 16'hffff, 16'hffff);   // unused opcode
        write_heap_bytes(17'd65536);
        send_op(OP_INIT, 16'd0, 16'd0);
        a = 16'd16; b = 16'd48; c = 16'd80;
        send_op(OP_ALLOC, 16'd24, 16'd0);
        send_op(OP_ALLOC, 16'd17, 16'd0);
        send_op(OP_ALLOC, 16'd0, 16'd0);
        send_op(OP_FREE, 16'd0, 16'd17);     // misaligned
        send_op(OP_FREE, 16'd0, b);
        send_op(OP_FREE, 16'd0, a);          // merge with next
        send_op(OP_FREE, 16'd0, c);          // merge both sides
        send_op(OP_ALLOC, 16'd65512, 16'd0); // largest that fits
        send_op(OP_ALLOC, 16'd0, 16'd0);
        send_op(OP_FREE, 16'd0, 16'd16);
        live_ptrs.delete();
        write_heap_bytes(17'h1ffff);         // clamps to max
        send_op(OP_INIT, 16'd0, 16'd0);
        send_op(OP_ALLOC, 16'd65528, 16'd0);
        write_heap_bytes(17'd5);             // clamps to min
        send_op(OP_INIT, 16'd0, 16'd0);
        send_op(OP_ALLOC, 16'd8, 16'd0);
        live_ptrs.delete();
    endtask

    task automatic test_random(input int n);
        logic [15:0] sz;
        sz = 16'd0;
        repeat (n) begin
            case ($urandom_range(0, 19))
                0: send_op(OP_INIT, 16'($urandom), 16'($urandom));
                1: send_op(2'd3, 16'($urandom), 16'($urandom));
                2, 3: sz = 16'($urandom);
                default: sz = 16'($urandom_range(0, 300));
            endcase
            if ($urandom_range(0, 1)) free_some();
            else send_op(OP_ALLOC, sz, 16'($urandom));
        end
    endtask

    task automatic test_sizes();
        logic [16:0] sizes [4] = '{17'd64, 17'd1000, 17'd4096, 17'd65535};
        foreach (sizes[i]) begin
            write_heap_bytes(sizes[i]);
            send_op(OP_INIT, 16'd0, 16'd0);
            live_ptrs.delete();
            test_random(250);
        end
    endtask

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h/%b",
                    rsp_ch.granted_pointer, rsp_ch.status);
            end else begin
                t_word e;
                e = expected_words.pop_front();
                words_checked++;
                if (e.granted_pointer !== rsp_ch.granted_pointer || e.status !== rsp_ch.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ptr %h status %b, got ptr %h status %b",
                            e.granted_pointer, e.status, rsp_ch.granted_pointer,
                            rsp_ch.status);
                end
            end
        end
    end

    // receiver stalls on its own pattern
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) rsp_stall_mode <= ~rsp_stall_mode;
        rsp_ch.ready <= rsp_stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_INIT;
        req_ch.request_size = '0;
        req_ch.release_pointer = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.heap_bytes = '0;
        mismatches = 0;
        words_checked = 0;
        allocs_ok = 0;
        allocs_failed = 0;
        frees_sent = 0;
        hp_head = '0;
        hp_in_use = '0;
        hp_cfg_bytes = HEAP_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_sizes();
        drain();
        test_random(100);
        drain();
        $display("covered %0d responses: %0d allocs granted, %0d refused, %0d frees",
            words_checked, allocs_ok, allocs_failed, frees_sent);
        $display("heap sizes from clamped minimum to clamped maximum");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
design/ffha_pkg.sv
design/ffha_if.sv
design/ffha_hdr_ram.sv
design/first_fit_heap_allocator.sv
sim/tb_first_fit_heap_allocator.sv
